/* rtl/core/hsvrgb_pkg.sv */
// hsvrgb_pkg: shared types and constants for the hsv to rgb converter
// used by hsvrgb_datapath and hsv_to_rgb_converter, no dependencies
`timescale 1ns / 1ps

package hsvrgb_pkg;

  localparam int LEVEL_W = 8;
  localparam int SCALED_W = 11;
  localparam int REGION_W = 3;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;
  localparam logic [2:0] SECTORS = 3'd6;

  localparam logic [REGION_W-1:0] REGION_RED_YEL = 3'd0;
  localparam logic [REGION_W-1:0] REGION_YEL_GRN = 3'd1;
  localparam logic [REGION_W-1:0] REGION_GRN_CYN = 3'd2;
  localparam logic [REGION_W-1:0] REGION_CYN_BLU = 3'd3;
  localparam logic [REGION_W-1:0] REGION_BLU_MAG = 3'd4;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

/* rtl/core/hsvrgb_datapath.sv */
// hsvrgb_datapath: four register stages of the hsv to rgb arithmetic
// depends on hsvrgb_pkg; stage enables come from the pipeline control in the top level
`timescale 1ns / 1ps

module hsvrgb_datapath
  import hsvrgb_pkg::*;
(
  input  logic               clk,
  input  stage_en_t          en,
  input  logic [LEVEL_W-1:0] hue,
  input  logic [LEVEL_W-1:0] saturation,
  input  logic [LEVEL_W-1:0] brightness,
  output logic [LEVEL_W-1:0] red_level,
  output logic [LEVEL_W-1:0] green_level,
  output logic [LEVEL_W-1:0] blue_level
);

  // stage 1
  logic [REGION_W-1:0] region1;
  logic [LEVEL_W-1:0]  frac1;
  logic [LEVEL_W-1:0]  sat1;
  logic [LEVEL_W-1:0]  val1;
  logic [LEVEL_W-1:0]  p1;
  logic                grey1;
  // stage 2
  logic [REGION_W-1:0] region2;
  logic [LEVEL_W-1:0]  val2;
  logic [LEVEL_W-1:0]  p2;
  logic [LEVEL_W-1:0]  sq2;
  logic [LEVEL_W-1:0]  st2;
  logic                grey2;
  // stage 3
  logic [REGION_W-1:0] region3;
  logic [LEVEL_W-1:0]  val3;
  logic [LEVEL_W-1:0]  p3;
  logic [LEVEL_W-1:0]  q3;
  logic [LEVEL_W-1:0]  t3;
  logic                grey3;

  logic [SCALED_W-1:0]  scaled;
  logic [2*LEVEL_W-1:0] p_prod;
  logic [2*LEVEL_W-1:0] sq_prod;
  logic [2*LEVEL_W-1:0] st_prod;
  logic [2*LEVEL_W-1:0] q_prod;
  logic [2*LEVEL_W-1:0] t_prod;
  logic [LEVEL_W-1:0]   red_next;
  logic [LEVEL_W-1:0]   green_next;
  logic [LEVEL_W-1:0]   blue_next;

  assign scaled  = SCALED_W'(hue) * SCALED_W'(SECTORS);
  assign p_prod  = {8'd0, brightness} * {8'd0, LEVEL_MAX - saturation};
  assign sq_prod = {8'd0, sat1} * {8'd0, frac1};
  assign st_prod = {8'd0, sat1} * {8'd0, LEVEL_MAX - frac1};
  assign q_prod  = {8'd0, val2} * {8'd0, LEVEL_MAX - sq2};
  assign t_prod  = {8'd0, val2} * {8'd0, LEVEL_MAX - st2};

  always_ff @(posedge clk) begin
    if (en.s1) begin
      region1 <= scaled[SCALED_W-1:LEVEL_W];
      frac1   <= scaled[LEVEL_W-1:0];
      sat1    <= saturation;
      val1    <= brightness;
      p1      <= p_prod[2*LEVEL_W-1:LEVEL_W];
      grey1   <= (saturation == '0);
    end
    if (en.s2) begin
      region2 <= region1;
      val2    <= val1;
      p2      <= p1;
      sq2     <= sq_prod[2*LEVEL_W-1:LEVEL_W];
      st2     <= st_prod[2*LEVEL_W-1:LEVEL_W];
      grey2   <= grey1;
    end
    if (en.s3) begin
      region3 <= region2;
      val3    <= val2;
      p3      <= p2;
      q3      <= q_prod[2*LEVEL_W-1:LEVEL_W];
      t3      <= t_prod[2*LEVEL_W-1:LEVEL_W];
      grey3   <= grey2;
    end
    if (en.s4) begin
      red_level   <= red_next;
      green_level <= green_next;
      blue_level  <= blue_next;
    end
  end

  // green and blue follow the swapped channel order
  always_comb begin
    if (grey3) begin
      red_next   = val3;
      green_next = val3;
      blue_next  = val3;
    end else begin
      case (region3)
        REGION_RED_YEL: begin
          red_next = val3; green_next = p3; blue_next = t3;
        end
        REGION_YEL_GRN: begin
          red_next = q3; green_next = p3; blue_next = val3;
        end
        REGION_GRN_CYN: begin
          red_next = p3; green_next = t3; blue_next = val3;
        end
        REGION_CYN_BLU: begin
          red_next = p3; green_next = val3; blue_next = q3;
        end
        REGION_BLU_MAG: begin
          red_next = t3; green_next = val3; blue_next = p3;
        end
        default: begin
          red_next = val3; green_next = q3; blue_next = p3;
        end
      endcase
    end
  end

endmodule

/* rtl/core/hsv_to_rgb_converter.sv */
// hsv_to_rgb_converter: 8-bit hsv pixel in, 8-bit rgb pixel out
// depends on hsvrgb_pkg and hsvrgb_datapath
//
// input channel: hue, saturation, brightness with hsv_valid / hsv_stall
// output channel: red_level, green_level, blue_level with rgb_valid / rgb_stall
// a transfer happens at a rising edge with valid high and stall low
// zero saturation gives a grey pixel at the brightness level
// green and blue use the swapped assignment of the original design
// pipeline: four register stages; an input transfer passes stages one to three before rgb_valid rises
// throughput: one pixel per cycle while the output is not stalled, set by the four-stage multiply pipeline
// each stage holds its own valid bit; a stage loads whenever it is empty or
// the stage after it moves, so bubbles are squeezed out under stall
// hsv_stall rises only when all four stages hold a pixel and rgb_stall is high
// a stalled result is held unchanged until it is taken
// reset (rst, synchronous, active high) empties the pipeline
`timescale 1ns / 1ps

module hsv_to_rgb_converter
  import hsvrgb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               hsv_valid,
  output logic               hsv_stall,
  input  logic [LEVEL_W-1:0] hue,
  input  logic [LEVEL_W-1:0] saturation,
  input  logic [LEVEL_W-1:0] brightness,
  output logic               rgb_valid,
  input  logic               rgb_stall,
  output logic [LEVEL_W-1:0] red_level,
  output logic [LEVEL_W-1:0] green_level,
  output logic [LEVEL_W-1:0] blue_level
);

  logic      v1;
  logic      v2;
  logic      v3;
  logic      ready1;
  logic      ready2;
  logic      ready3;
  logic      ready4;
  stage_en_t en;

  assign ready4    = !rgb_valid || !rgb_stall;
  assign ready3    = !v3 || ready4;
  assign ready2    = !v2 || ready3;
  assign ready1    = !v1 || ready2;
  assign hsv_stall = !ready1;

  assign en.s1 = ready1;
  assign en.s2 = ready2;
  assign en.s3 = ready3;
  assign en.s4 = ready4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      rgb_valid <= 1'b0;
    end else begin
      if (ready1) v1 <= hsv_valid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
      if (ready4) rgb_valid <= v3;
    end
  end

  hsvrgb_datapath u_datapath (
    .clk         (clk),
    .en          (en),
    .hue         (hue),
    .saturation  (saturation),
    .brightness  (brightness),
    .red_level   (red_level),
    .green_level (green_level),
    .blue_level  (blue_level)
  );

  // input stalls only with a full pipeline and a stalled output
  assert property (@(posedge clk) disable iff (rst)
    hsv_stall |-> (v1 && v2 && v3 && rgb_valid && rgb_stall))
    else $error("input stalled while pipeline has room");

  // an input transfer lands in stage one
  assert property (@(posedge clk) disable iff (rst)
    (hsv_valid && !hsv_stall) |=> v1)
    else $error("input transfer lost at stage one");

  // a pixel in stage three reaches the output or stays put
  assert property (@(posedge clk) disable iff (rst)
    v3 |=> (rgb_valid || v3))
    else $error("pixel dropped between stage three and output");

  // reset empties the pipeline
  assert property (@(posedge clk)
    $past(rst) |-> (!v1 && !v2 && !v3 && !rgb_valid))
    else $error("pipeline not empty after reset");

endmodule
